[design/dib_pixel_unpacker_assert.svh]
// ----------------------------------------------------------------------------
// DIB pixel unpacker assertion macros
// Concurrent checks on the clock clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIB_PIXEL_UNPACKER_ASSERT_SVH
`define DIB_PIXEL_UNPACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DPU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define DPU_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define DPU_ASSERT(name, prop, msg)

`define DPU_ASSERT_NEVER(name, cond, msg)

`endif

`endif

[design/dpu_pkg.sv]
// ----------------------------------------------------------------------------
// DIB pixel unpacker package
// Shared constants, codes and the queue word between front and back.
// ----------------------------------------------------------------------------
package dpu_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int WIDTH_CAP     = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam int HEIGHT_CAP    = 4096;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam int CFG_W   = 13;
	localparam int COORD_W = 12;
	localparam int POS_W   = 15;

	localparam logic [1:0] FMT_PAL8   = 2'd0;
	localparam logic [1:0] FMT_RGB555 = 2'd1;
	localparam logic [1:0] FMT_BGR24  = 2'd2;
	localparam logic [1:0] FMT_BGRA32 = 2'd3;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic REQ_PALETTE = 1'b0;
	localparam logic REQ_DATA    = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [4:0] CH5_MASK     = 5'h1F;

	typedef struct packed {
		logic               is_pal;
		logic [1:0]         fmt;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
		logic [23:0]        data;
		logic [7:0]         aux;
	} dpu_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dpu_q_status_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [4:0] m;
		m = v & CH5_MASK;
		return {m, m[4:2]};
	endfunction

endpackage

[design/dpu_front.sv]
// ----------------------------------------------------------------------------
// DIB pixel unpacker front
// Holds configuration, tracks the row position, gathers pixel bytes and
// pushes palette writes and completed pixels into the queue.
// ----------------------------------------------------------------------------
module dpu_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [dpu_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [7:0]                  palette_index,
	input  logic [7:0]                  palette_red,
	input  logic [7:0]                  palette_green,
	input  logic [7:0]                  palette_blue,
	input  logic [7:0]                  data_byte,
	input  dpu_pkg::dpu_q_status_t      q_status,
	output logic                        q_push,
	output dpu_pkg::dpu_entry_t         q_entry
);
	import dpu_pkg::*;

	logic [1:0]         fmt_q;
	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [23:0]        pixel_q;
	logic [1:0]         phase_q;
	logic [POS_W-1:0]   pos_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;

	logic [CFG_W-1:0]   eff_w;
	logic [CFG_W-1:0]   eff_h;
	logic [POS_W-1:0]   w_ext;
	logic [POS_W-1:0]   row_len;
	logic [POS_W-1:0]   pitch;
	logic [POS_W-1:0]   pos_next;
	logic [CFG_W-1:0]   row_inc;
	logic [23:0]        merged;
	logic               accept;
	logic               is_data;
	logic               in_row;
	logic               complete;
	logic               row_end;
	logic               cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			eff_w = CFG_W'(1);
		end else if (width_q > CFG_W'(WIDTH_CAP)) begin
			eff_w = CFG_W'(WIDTH_CAP);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = CFG_W'(1);
		end else if (height_q > CFG_W'(HEIGHT_CAP)) begin
			eff_h = CFG_W'(HEIGHT_CAP);
		end else begin
			eff_h = height_q;
		end
	end

	assign w_ext = POS_W'(eff_w);

	always_comb begin
		case (fmt_q)
			FMT_PAL8:   row_len = w_ext;
			FMT_RGB555: row_len = w_ext << 1;
			FMT_BGR24:  row_len = (w_ext << 1) + w_ext;
			FMT_BGRA32: row_len = w_ext << 2;
			default:    row_len = w_ext;
		endcase
		if (fmt_q == FMT_BGRA32) begin
			pitch = row_len;
		end else begin
			pitch = (row_len + POS_W'(3)) & ~POS_W'(3);
		end
	end

	always_comb begin
		case (phase_q)
			2'd0:    merged = pixel_q | {16'd0, data_byte};
			2'd1:    merged = pixel_q | {8'd0, data_byte, 8'd0};
			2'd2:    merged = pixel_q | {data_byte, 16'd0};
			default: merged = pixel_q;
		endcase
	end

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign is_data  = (req_type == REQ_DATA);
	assign in_row   = (pos_q < row_len);
	assign complete = in_row && (phase_q == fmt_q);
	assign pos_next = pos_q + POS_W'(1);
	assign row_end  = (pos_next >= pitch);
	assign row_inc  = CFG_W'(row_q) + CFG_W'(1);
	assign cfg_hit  = cfg_wr_en &&
		(cfg_index == REG_FORMAT || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	assign q_push = accept && (!is_data || complete);

	always_comb begin
		q_entry.is_pal = !is_data;
		q_entry.fmt    = fmt_q;
		q_entry.x      = col_q;
		q_entry.y      = COORD_W'(eff_h - CFG_W'(1) - CFG_W'(row_q));
		q_entry.last   = (CFG_W'(row_q) == eff_h - CFG_W'(1)) &&
			(CFG_W'(col_q) == eff_w - CFG_W'(1));
		q_entry.data   = is_data ? merged : {palette_red, palette_green, palette_blue};
		q_entry.aux    = is_data ? data_byte : palette_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_BGR24;
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			pixel_q  <= '0;
			phase_q  <= '0;
			pos_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    fmt_q    <= fmt_q;
			endcase
			pixel_q <= '0;
			phase_q <= '0;
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept && is_data) begin
			if (row_end) begin
				pos_q   <= '0;
				col_q   <= '0;
				phase_q <= '0;
				pixel_q <= '0;
				row_q   <= (row_inc >= eff_h) ? '0 : row_inc[COORD_W-1:0];
			end else begin
				pos_q <= pos_next;
				if (complete) begin
					pixel_q <= '0;
					phase_q <= '0;
					col_q   <= col_q + COORD_W'(1);
				end else if (in_row) begin
					pixel_q <= merged;
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

endmodule

[design/dpu_fifo.sv]
// ----------------------------------------------------------------------------
// DIB pixel unpacker queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dpu_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dpu_pkg::dpu_entry_t    wr_entry,
	input  logic                   pop,
	output dpu_pkg::dpu_entry_t    rd_entry,
	output dpu_pkg::dpu_q_status_t status
);
	import dpu_pkg::*;

	dpu_entry_t      slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign status.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_entry     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/dpu_back.sv]
// ----------------------------------------------------------------------------
// DIB pixel unpacker back
// Writes palette entries, looks up indexed pixels, expands 555 channels and
// drives the registered result word.
// ----------------------------------------------------------------------------
module dpu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpu_pkg::dpu_q_status_t        q_status,
	input  dpu_pkg::dpu_entry_t           q_entry,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dpu_pkg::COORD_W-1:0]   pixel_x,
	output logic [dpu_pkg::COORD_W-1:0]   pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          last_pixel
);
	import dpu_pkg::*;

	logic [23:0]        pal_mem [PALETTE_DEPTH];

	dpu_entry_t         entry_s1;
	logic [23:0]        pal_rd_s1;
	logic               hit_s1;
	logic               valid_s1;

	logic               valid_s2;
	logic [COORD_W-1:0] x_s2;
	logic [COORD_W-1:0] y_s2;
	logic [7:0]         red_s2;
	logic [7:0]         green_s2;
	logic [7:0]         blue_s2;
	logic [7:0]         alpha_s2;
	logic               last_s2;

	logic               load_s2;
	logic               free_s1;
	logic               load_pixel;
	logic               wr_hit;
	logic               rd_hit;
	logic [7:0]         red_c;
	logic [7:0]         green_c;
	logic [7:0]         blue_c;
	logic [7:0]         alpha_c;

	assign load_s2    = valid_s1 && (!valid_s2 || !out_stall);
	assign free_s1    = !valid_s1 || load_s2;
	assign q_pop      = !q_status.empty && (q_entry.is_pal || free_s1);
	assign load_pixel = q_pop && !q_entry.is_pal;
	assign wr_hit     = ({1'b0, q_entry.aux} < 9'(PALETTE_DEPTH));
	assign rd_hit     = ({1'b0, q_entry.data[7:0]} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.is_pal && wr_hit) begin
			pal_mem[q_entry.aux[PAL_AW-1:0]] <= q_entry.data;
		end
		if (load_pixel) begin
			pal_rd_s1 <= pal_mem[q_entry.data[PAL_AW-1:0]];
			entry_s1  <= q_entry;
			hit_s1    <= rd_hit;
		end
	end

	always_comb begin
		alpha_c = ALPHA_OPAQUE;
		case (entry_s1.fmt)
			FMT_PAL8: begin
				red_c   = hit_s1 ? pal_rd_s1[23:16] : 8'd0;
				green_c = hit_s1 ? pal_rd_s1[15:8]  : 8'd0;
				blue_c  = hit_s1 ? pal_rd_s1[7:0]   : 8'd0;
			end
			FMT_RGB555: begin
				red_c   = widen5(entry_s1.data[14:10]);
				green_c = widen5(entry_s1.data[9:5]);
				blue_c  = widen5(entry_s1.data[4:0]);
			end
			FMT_BGRA32: begin
				red_c   = entry_s1.data[23:16];
				green_c = entry_s1.data[15:8];
				blue_c  = entry_s1.data[7:0];
				alpha_c = entry_s1.aux;
			end
			default: begin
				red_c   = entry_s1.data[23:16];
				green_c = entry_s1.data[15:8];
				blue_c  = entry_s1.data[7:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			x_s2     <= entry_s1.x;
			y_s2     <= entry_s1.y;
			red_s2   <= red_c;
			green_s2 <= green_c;
			blue_s2  <= blue_c;
			alpha_s2 <= alpha_c;
			last_s2  <= entry_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_pixel) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign pixel_x    = x_s2;
	assign pixel_y    = y_s2;
	assign red        = red_s2;
	assign green      = green_s2;
	assign blue       = blue_s2;
	assign alpha      = alpha_s2;
	assign last_pixel = last_s2;

endmodule

[design/dib_pixel_unpacker.sv]
// Takes one bitmap byte or palette write per clock and gives RGBA pixels in
// bottom-up row order with flipped row numbers. A byte is accepted every
// cycle while the four-word queue between the front and the back has room;
// a pixel whose last byte is taken is written into a queue slot, then into
// the palette read register and then into the output word. The palette is a
// 256-entry memory with a registered read.
// ----------------------------------------------------------------------------
// DIB pixel unpacker top level
// Front, queue and back wired together, with the run-time checks.
// ----------------------------------------------------------------------------
`include "dib_pixel_unpacker_assert.svh"

module dib_pixel_unpacker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [dpu_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [7:0]                  palette_index,
	input  logic [7:0]                  palette_red,
	input  logic [7:0]                  palette_green,
	input  logic [7:0]                  palette_blue,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [dpu_pkg::COORD_W-1:0] pixel_x,
	output logic [dpu_pkg::COORD_W-1:0] pixel_y,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic [7:0]                  alpha,
	output logic                        last_pixel
);
	import dpu_pkg::*;

	dpu_q_status_t q_status;
	dpu_entry_t    push_entry;
	dpu_entry_t    head_entry;
	logic          q_push;
	logic          q_pop;

	dpu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.data_byte     (data_byte),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_entry       (push_entry)
	);

	dpu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.status   (q_status)
	);

	dpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_entry    (head_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

	`DPU_ASSERT_NEVER(a_push_full, q_push && q_status.full, "push into a full queue")
	`DPU_ASSERT_NEVER(a_pop_empty, q_pop && q_status.empty, "pop from an empty queue")
	`DPU_ASSERT(a_last_top_row, out_valid && last_pixel |-> pixel_y == '0, "last pixel off row 0")

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DIB pixel unpacker testbench
// Streams palette writes and bitmap bytes through the unpacker under random
// idle and stall, predicts every RGBA pixel with its coordinates and the
// end-of-image flag, and compares each delivered pixel with the oldest one due.
// ----------------------------------------------------------------------------
module tb;
	import dpu_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int         LIMIT     = 1000000;
	localparam int         RAND_WORDS = 840;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [7:0]         a;
		logic               last;
	} pixel_t;

	class dib_decoder;
		logic [23:0]  palette [256];
		bit           written [256];
		logic [7:0]   loaded[$];
		logic [1:0]   fmt;
		logic [12:0]  width_reg;
		logic [12:0]  height_reg;
		logic [23:0]  acc;
		int unsigned  phase;
		int unsigned  row_pos;
		int unsigned  col;
		int unsigned  src_row;
		pixel_t       due_pixels[$];
		int           bad_pixels;

		function new();
			fmt = FMT_BGR24;
			width_reg = 13'd1;
			height_reg = 13'd1;
			bad_pixels = 0;
			clear_pos();
		endfunction

		function void clear_pos();
			acc = '0;
			phase = 0;
			row_pos = 0;
			col = 0;
			src_row = 0;
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > WIDTH_CAP) w = WIDTH_CAP;
			return w;
		endfunction

		function int unsigned eff_height();
			int unsigned h;
			h = height_reg;
			if (h == 0) h = 1;
			if (h > HEIGHT_CAP) h = HEIGHT_CAP;
			return h;
		endfunction

		function int unsigned pitch();
			int unsigned p;
			p = eff_width() * (fmt + 1);
			if (fmt != FMT_BGRA32) p = (p + 3) / 4 * 4;
			return p;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_FORMAT: fmt = val[1:0];
				REG_WIDTH: width_reg = val;
				REG_HEIGHT: height_reg = val;
				default: return;
			endcase
			clear_pos();
		endfunction

		function bit index_due();
			return fmt == FMT_PAL8 && row_pos < eff_width();
		endfunction

		function logic [7:0] spread5(logic [4:0] v);
			return {v, v[4:2]};
		endfunction

		function void take_word(logic req, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] data);
			int unsigned w;
			int unsigned h;
			int unsigned bpp;
			logic [23:0] full;
			pixel_t      px;
			if (req == REQ_PALETTE) begin
				palette[idx] = {r, g, b};
				if (!written[idx]) begin
					written[idx] = 1'b1;
					loaded.insert(loaded.size(), idx);
				end
				return;
			end
			w = eff_width();
			h = eff_height();
			bpp = fmt + 1;
			if (row_pos < w * bpp) begin
				if (phase + 1 < bpp) begin
					acc[8*phase +: 8] = data;
					phase++;
				end else begin
					full = acc;
					if (bpp < 4) full[8*phase +: 8] = data;
					px.a = ALPHA_OPAQUE;
					case (fmt)
						FMT_PAL8: {px.r, px.g, px.b} = palette[full[7:0]];
						FMT_RGB555: begin
							px.r = spread5(full[14:10]);
							px.g = spread5(full[9:5]);
							px.b = spread5(full[4:0]);
						end
						FMT_BGR24: {px.r, px.g, px.b} = full;
						default: begin
							{px.r, px.g, px.b} = full;
							px.a = data;
						end
					endcase
					px.x = col[COORD_W-1:0];
					px.y = COORD_W'(h - 1 - src_row);
					px.last = (src_row == h - 1) && (col == w - 1);
					due_pixels.insert(due_pixels.size(), px);
					acc = '0;
					phase = 0;
					col++;
				end
			end
			row_pos++;
			if (row_pos >= pitch()) begin
				row_pos = 0;
				col = 0;
				phase = 0;
				acc = '0;
				src_row++;
				if (src_row >= h) src_row = 0;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (due_pixels.size() == 0) begin
				bad_pixels++;
				if (bad_pixels <= 10)
					$display("mismatch: pixel with none due",
						" x=%0d y=%0d rgba=%h%h%h%h last=%0d",
						got.x, got.y, got.r, got.g, got.b, got.a, got.last);
				return;
			end
			want = due_pixels.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
				got.g !== want.g || got.b !== want.b || got.a !== want.a ||
				got.last !== want.last) begin
				bad_pixels++;
				if (bad_pixels <= 10)
					$display("mismatch: exp x=%0d y=%0d rgba=%h%h%h%h last=%0d,",
						want.x, want.y, want.r, want.g, want.b, want.a, want.last,
						" got x=%0d y=%0d rgba=%h%h%h%h last=%0d",
						got.x, got.y, got.r, got.g, got.b, got.a, got.last);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = 1'b0;
	logic [7:0]         palette_index = '0;
	logic [7:0]         palette_red = '0;
	logic [7:0]         palette_green = '0;
	logic [7:0]         palette_blue = '0;
	logic [7:0]         data_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	logic               last_pixel;

	dib_decoder         sb = new();
	bit                 no_idle = 1'b0;
	int                 cycles = 0;

	dib_pixel_unpacker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.palette_index(palette_index),
		.palette_red(palette_red),
		.palette_green(palette_green),
		.palette_blue(palette_blue),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_pixel(last_pixel)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel({pixel_x, pixel_y, red, green, blue, alpha, last_pixel});
	end

	initial begin
		int unsigned hold;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				hold = no_idle ? 0 : $urandom_range(0, 10);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_word(input logic req, input logic [7:0] idx, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] data);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		palette_index <= idx;
		palette_red <= r;
		palette_green <= g;
		palette_blue <= b;
		data_byte <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.take_word(req, idx, r, g, b, data);
	endtask

	task automatic send_pal(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		send_word(REQ_PALETTE, idx, r, g, b, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] data);
		send_word(REQ_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data);
	endtask

	// palette lookups only hit loaded entries
	task automatic send_any_byte();
		logic [7:0] data;
		data = 8'($urandom);
		if (sb.index_due()) data = sb.loaded[$urandom_range(0, sb.loaded.size() - 1)];
		send_byte(data);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(input logic [CFG_W-1:0] f, input logic [CFG_W-1:0] w,
		input logic [CFG_W-1:0] h);
		write_reg(REG_FORMAT, f);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		int unsigned img;
		int unsigned pick;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pal(8'h00, 8'h00, 8'h00, 8'h00);
		send_pal(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pal(8'hA5, 8'hAA, 8'h55, 8'h0F);
		// reset geometry: one 24-bit pixel per image plus a pad byte
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte(8'h7E);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		drain();
		configure(CFG_W'(FMT_PAL8), CFG_W'(3), CFG_W'(2));
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h81);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h18);
		drain();
		configure(CFG_W'(FMT_RGB555), CFG_W'(2), CFG_W'(1));
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		drain();
		configure(CFG_W'(FMT_BGRA32), CFG_W'(1), CFG_W'(1));
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'h04);

		sent = 0;
		while (sent < RAND_WORDS) begin
			drain();
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
			pick = $urandom_range(0, 19);
			if (pick == 0) w = '0;
			else if (pick == 1) w = CFG_W'($urandom_range(4097, 8191));
			else if (pick == 2) w = CFG_W'(4096);
			else w = CFG_W'($urandom_range(1, 9));
			pick = $urandom_range(0, 19);
			if (pick == 0) h = '0;
			else if (pick == 1) h = CFG_W'($urandom_range(4096, 8191));
			else h = CFG_W'($urandom_range(1, 4));
			if ($urandom_range(0, 3) != 0) write_reg(REG_FORMAT, CFG_W'($urandom));
			if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, w);
			if ($urandom_range(0, 3) != 0) write_reg(REG_HEIGHT, h);
			cfg_wr_en <= 1'b0;
			img = sb.pitch() * sb.eff_height();
			n = $urandom_range(1, 3) * img + $urandom_range(0, img);
			if (n > 300) n = $urandom_range(100, 300);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0)
					send_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				else
					send_any_byte();
			end
			sent += n;
		end

		// widest row, clamped width and zero height
		drain();
		no_idle = 1'b0;
		configure({11'h7FF, FMT_PAL8}, 13'h1FFF, '0);
		repeat (40) send_any_byte();
		drain();
		configure({11'h7FF, FMT_BGRA32}, CFG_W'(1), 13'h1FFF);
		repeat (8) send_any_byte();
		drain();
		configure(CFG_W'(FMT_BGR24), CFG_W'(4096), CFG_W'(4096));
		repeat (40) send_any_byte();
		drain();

		if (sb.bad_pixels == 0 && sb.due_pixels.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
